// ===== hw/rtl/grhs_pkg.sv =====
`default_nettype none

package grhs_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned QUO_W         = 32;

  localparam logic [31:0] ACC_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ACC_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] metric_xx;
    logic signed [31:0] metric_xy;
    logic signed [31:0] metric_yy;
    logic signed [31:0] ddx_xx;
    logic signed [31:0] ddx_xy;
    logic signed [31:0] ddx_yy;
    logic signed [31:0] ddy_xx;
    logic signed [31:0] ddy_xy;
    logic signed [31:0] ddy_yy;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } in_item_t;

  // contracted Christoffel terms plus what the inversion still needs
  typedef struct packed {
    logic signed [63:0] h0;
    logic signed [63:0] h1;
    logic signed [63:0] det;
    logic signed [31:0] g_xx;
    logic signed [31:0] g_xy;
    logic signed [31:0] g_yy;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } chr_item_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] num_lo;
    logic [31:0] quo;
    logic        ovf;
    logic        neg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [1:0]    lane;
    logic [63:0]        dmag;
    logic               singular;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } div_item_t;

  typedef struct packed {
    logic [31:0] deriv_x;
    logic [31:0] deriv_y;
    logic [31:0] accel_x;
    logic [31:0] accel_y;
    logic        singular;
  } res_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/grhs_chr.sv =====
`default_nettype none

module grhs_chr #(
  parameter int unsigned FRAC_BITS = grhs_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  grhs_pkg::in_item_t  item_i,
  output logic                valid_o,
  output grhs_pkg::chr_item_t item_o
);

  localparam int unsigned NSTG   = 6;
  localparam int unsigned PART_W = 67;
  localparam int unsigned SUM_W  = 100;
  localparam int unsigned SHIFT  = 2 * FRAC_BITS + 1;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (2 * FRAC_BITS);

  typedef struct packed {
    logic signed [31:0] g_xx;
    logic signed [31:0] g_xy;
    logic signed [31:0] g_yy;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } side_t;

  logic [NSTG-1:0]          v_q;
  side_t                    side_d;
  side_t                    side_q [NSTG];
  logic signed [63:0]       detp_q, detq_q;
  logic signed [63:0]       det_q [1:NSTG-1];
  logic signed [63:0]       p_q [3];
  logic signed [33:0]       coef_q [2][3];
  logic signed [PART_W-1:0] hi_q [2][3];
  logic signed [PART_W-1:0] lo_q [2][3];
  logic signed [SUM_W-1:0]  term_q [2][3];
  logic signed [SUM_W-1:0]  sum_q [2];
  logic signed [SUM_W-1:0]  rnd_q [2];
  logic signed [63:0]       h_q [2];

  function automatic logic signed [63:0] sat64(logic signed [SUM_W-1:0] x);
    logic in_range;
    in_range = (&x[SUM_W-1:63]) || (~|x[SUM_W-1:63]);
    if (in_range) return x[63:0];
    else if (x[SUM_W-1]) return {1'b1, 63'd0};
    else return {1'b0, {63{1'b1}}};
  endfunction

  always_comb begin
    side_d.g_xx  = item_i.metric_xx;
    side_d.g_xy  = item_i.metric_xy;
    side_d.g_yy  = item_i.metric_yy;
    side_d.vel_x = item_i.vel_x;
    side_d.vel_y = item_i.vel_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_d;
      for (int s = 1; s < NSTG; s++) side_q[s] <= side_q[s-1];

      // products of the metric and the velocity
      detp_q <= 64'(item_i.metric_xx) * 64'(item_i.metric_yy);
      detq_q <= 64'(item_i.metric_xy) * 64'(item_i.metric_xy);
      p_q[0] <= 64'(item_i.vel_x) * 64'(item_i.vel_x);
      p_q[1] <= 64'(item_i.vel_x) * 64'(item_i.vel_y);
      p_q[2] <= 64'(item_i.vel_y) * 64'(item_i.vel_y);

      // symbol coefficients per (m, vxvx / vxvy / vyvy); the cross term is doubled later
      coef_q[0][0] <= 34'(item_i.ddx_xx);
      coef_q[0][1] <= 34'(item_i.ddy_xx);
      coef_q[0][2] <= (34'(item_i.ddy_xy) <<< 1) - 34'(item_i.ddx_yy);
      coef_q[1][0] <= (34'(item_i.ddx_xy) <<< 1) - 34'(item_i.ddy_xx);
      coef_q[1][1] <= 34'(item_i.ddx_yy);
      coef_q[1][2] <= 34'(item_i.ddy_yy);

      det_q[1] <= detp_q - detq_q;
      for (int s = 2; s < NSTG; s++) det_q[s] <= det_q[s-1];

      // 34 x 64 products split into two partials on the halves of P
      for (int m = 0; m < 2; m++) begin
        for (int j = 0; j < 3; j++) begin
          hi_q[m][j] <= PART_W'(coef_q[m][j]) * PART_W'($signed(p_q[j][63:32]));
          lo_q[m][j] <= PART_W'(coef_q[m][j]) * PART_W'($signed({1'b0, p_q[j][31:0]}));
          term_q[m][j] <= (SUM_W'(hi_q[m][j]) <<< 32) + SUM_W'(lo_q[m][j]);
        end
        sum_q[m] <= term_q[m][0] + (term_q[m][1] <<< 1) + term_q[m][2];
        rnd_q[m] <= (sum_q[m] + RND) >>> SHIFT;
        h_q[m]   <= sat64(rnd_q[m]);
      end
    end
  end

  assign valid_o      = v_q[NSTG-1];
  assign item_o.h0    = h_q[0];
  assign item_o.h1    = h_q[1];
  assign item_o.det   = det_q[NSTG-1];
  assign item_o.g_xx  = side_q[NSTG-1].g_xx;
  assign item_o.g_xy  = side_q[NSTG-1].g_xy;
  assign item_o.g_yy  = side_q[NSTG-1].g_yy;
  assign item_o.vel_x = side_q[NSTG-1].vel_x;
  assign item_o.vel_y = side_q[NSTG-1].vel_y;

endmodule

`default_nettype wire

// ===== hw/rtl/grhs_inv.sv =====
`default_nettype none

module grhs_inv #(
  parameter int unsigned FRAC_BITS = grhs_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  grhs_pkg::chr_item_t item_i,
  output logic                valid_o,
  output grhs_pkg::div_item_t item_o
);

  localparam int unsigned NSTG   = 6;
  localparam int unsigned PART_W = 65;
  localparam int unsigned PROD_W = 97;
  localparam int unsigned N_W    = 98;
  localparam int unsigned MAG_W  = 97;
  localparam int unsigned NUM_W  = MAG_W + FRAC_BITS + 1;

  typedef struct packed {
    logic signed [63:0] det;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } head_t;

  typedef struct packed {
    logic [63:0]        dmag;
    logic               det_neg;
    logic               singular;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } tail_t;

  logic [NSTG-1:0]          v_q;
  head_t                    head_d;
  head_t                    head_q [1:3];
  tail_t                    tail_q [4:5];
  logic signed [31:0]       g_sel [4];
  logic signed [63:0]       h_sel [4];
  logic signed [PART_W-1:0] hi_q [4];
  logic signed [PART_W-1:0] lo_q [4];
  logic signed [PROD_W-1:0] prod_q [4];
  logic signed [N_W-1:0]    n_q [2];
  logic                     nneg_q [2];
  logic                     nzero_q [2];
  logic [MAG_W-1:0]         nmag_q [2];
  logic [NUM_W-1:0]         num_q [2];
  logic                     neg_q [2];
  grhs_pkg::div_item_t      out_q;

  // N0 = yy*h0 - xy*h1, N1 = xx*h1 - xy*h0
  always_comb begin
    g_sel[0] = item_i.g_yy;
    g_sel[1] = item_i.g_xy;
    g_sel[2] = item_i.g_xy;
    g_sel[3] = item_i.g_xx;
    h_sel[0] = item_i.h0;
    h_sel[1] = item_i.h1;
    h_sel[2] = item_i.h0;
    h_sel[3] = item_i.h1;
    head_d.det   = item_i.det;
    head_d.vel_x = item_i.vel_x;
    head_d.vel_y = item_i.vel_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      head_q[1] <= head_d;
      head_q[2] <= head_q[1];
      head_q[3] <= head_q[2];

      for (int p = 0; p < 4; p++) begin
        hi_q[p]   <= PART_W'(g_sel[p]) * PART_W'($signed(h_sel[p][63:32]));
        lo_q[p]   <= PART_W'(g_sel[p]) * PART_W'($signed({1'b0, h_sel[p][31:0]}));
        prod_q[p] <= (PROD_W'(hi_q[p]) <<< 32) + PROD_W'(lo_q[p]);
      end
      n_q[0] <= N_W'(prod_q[0]) - N_W'(prod_q[1]);
      n_q[1] <= N_W'(prod_q[3]) - N_W'(prod_q[2]);

      tail_q[4].dmag     <= head_q[3].det[63] ? 64'(-head_q[3].det) : 64'(head_q[3].det);
      tail_q[4].det_neg  <= head_q[3].det[63];
      tail_q[4].singular <= (head_q[3].det == '0);
      tail_q[4].vel_x    <= head_q[3].vel_x;
      tail_q[4].vel_y    <= head_q[3].vel_y;
      tail_q[5]          <= tail_q[4];

      for (int i = 0; i < 2; i++) begin
        nneg_q[i]  <= n_q[i][N_W-1];
        nzero_q[i] <= (n_q[i] == '0);
        nmag_q[i]  <= n_q[i][N_W-1] ? MAG_W'(-n_q[i]) : MAG_W'(n_q[i]);
        // scaled magnitude plus half the divisor, for round to nearest
        num_q[i]   <= (NUM_W'(nmag_q[i]) << FRAC_BITS) + NUM_W'(tail_q[4].dmag >> 1);
        neg_q[i]   <= !nzero_q[i] && (nneg_q[i] == tail_q[4].det_neg);

        // quotient of 2^32 or more saturates; otherwise the upper part is the start remainder
        out_q.lane[i].ovf    <= (num_q[i][NUM_W-1:32] >= (NUM_W-32)'(tail_q[5].dmag));
        out_q.lane[i].rem    <= num_q[i][95:32];
        out_q.lane[i].num_lo <= num_q[i][31:0];
        out_q.lane[i].quo    <= '0;
        out_q.lane[i].neg    <= neg_q[i];
      end
      out_q.dmag     <= tail_q[5].dmag;
      out_q.singular <= tail_q[5].singular;
      out_q.vel_x    <= tail_q[5].vel_x;
      out_q.vel_y    <= tail_q[5].vel_y;
    end
  end

  assign valid_o = v_q[NSTG-1];
  assign item_o  = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/grhs_div.sv =====
`default_nettype none

module grhs_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  grhs_pkg::div_item_t item_i,
  output logic                valid_o,
  output grhs_pkg::res_item_t item_o
);

  localparam int unsigned NSTG = grhs_pkg::QUO_W + 1;

  logic [NSTG-1:0]     v_q;
  grhs_pkg::div_item_t stg_q [grhs_pkg::QUO_W];
  grhs_pkg::res_item_t res_q;

  // one restoring step per lane: one quotient bit
  function automatic grhs_pkg::div_item_t div_step(grhs_pkg::div_item_t x);
    grhs_pkg::div_item_t y;
    logic [63:0]         r;
    logic [64:0]         trial;
    y = x;
    for (int i = 0; i < 2; i++) begin
      r     = {x.lane[i].rem[62:0], x.lane[i].num_lo[31]};
      trial = {1'b0, r} - {1'b0, x.dmag};
      if (!trial[64]) begin
        y.lane[i].rem = trial[63:0];
        y.lane[i].quo = {x.lane[i].quo[30:0], 1'b1};
      end else begin
        y.lane[i].rem = r;
        y.lane[i].quo = {x.lane[i].quo[30:0], 1'b0};
      end
      y.lane[i].num_lo = {x.lane[i].num_lo[30:0], 1'b0};
    end
    return y;
  endfunction

  function automatic logic [31:0] lane_result(grhs_pkg::div_lane_t l, logic singular);
    logic [31:0] a;
    if (singular) begin
      a = '0;
    end else if (l.neg) begin
      a = (l.ovf || l.quo > grhs_pkg::ACC_MIN) ? grhs_pkg::ACC_MIN : (~l.quo + 32'd1);
    end else begin
      a = (l.ovf || l.quo[31]) ? grhs_pkg::ACC_MAX : l.quo;
    end
    return a;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q[0] <= div_step(item_i);
      for (int k = 1; k < grhs_pkg::QUO_W; k++) stg_q[k] <= div_step(stg_q[k-1]);
      res_q.deriv_x  <= stg_q[grhs_pkg::QUO_W-1].vel_x;
      res_q.deriv_y  <= stg_q[grhs_pkg::QUO_W-1].vel_y;
      res_q.accel_x  <= lane_result(stg_q[grhs_pkg::QUO_W-1].lane[0],
                                    stg_q[grhs_pkg::QUO_W-1].singular);
      res_q.accel_y  <= lane_result(stg_q[grhs_pkg::QUO_W-1].lane[1],
                                    stg_q[grhs_pkg::QUO_W-1].singular);
      res_q.singular <= stg_q[grhs_pkg::QUO_W-1].singular;
    end
  end

  assign valid_o = v_q[NSTG-1];
  assign item_o  = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/geodesic_rhs_2d.sv =====
// Throughput: one word per cycle while input ready is high; the 32-stage quotient pipeline
// sets the depth, not the rate. A stalled output parks one result in a skid register;
// input ready drops only when it is full. Reset (rst_ni low, asynchronous) clears all
// valid bits and the output/skid flags; datapath registers are not reset.
`default_nettype none

module geodesic_rhs_2d #(
  parameter int unsigned FRAC_BITS = grhs_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // metric_xx, metric_xy, metric_yy, ddx_xx, ddx_xy, ddx_yy, ddy_xx, ddy_xy, ddy_yy,
  // vel_x, vel_y; 32 bits each from bit 0 up
  input  logic [351:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // deriv_x, deriv_y, accel_x, accel_y; 32 bits each from bit 0 up
  output logic [127:0] m_axis_tdata,
  // singular
  output logic         m_axis_tuser
);

  logic                en;
  grhs_pkg::in_item_t  in_item;
  logic                chr_valid, inv_valid, div_valid;
  grhs_pkg::chr_item_t chr_item;
  grhs_pkg::div_item_t inv_item;
  grhs_pkg::res_item_t div_item;
  grhs_pkg::res_item_t out_q, sk_q;
  logic                out_v_q, out_v_d, sk_v_q, sk_v_d;
  logic                push, out_ld, sk_ld;

  assign in_item.metric_xx = s_axis_tdata[31:0];
  assign in_item.metric_xy = s_axis_tdata[63:32];
  assign in_item.metric_yy = s_axis_tdata[95:64];
  assign in_item.ddx_xx    = s_axis_tdata[127:96];
  assign in_item.ddx_xy    = s_axis_tdata[159:128];
  assign in_item.ddx_yy    = s_axis_tdata[191:160];
  assign in_item.ddy_xx    = s_axis_tdata[223:192];
  assign in_item.ddy_xy    = s_axis_tdata[255:224];
  assign in_item.ddy_yy    = s_axis_tdata[287:256];
  assign in_item.vel_x     = s_axis_tdata[319:288];
  assign in_item.vel_y     = s_axis_tdata[351:320];

  // whole pipeline advances unless the skid register is holding a word
  assign en            = !sk_v_q;
  assign s_axis_tready = en;
  assign push          = en && div_valid;

  grhs_chr #(.FRAC_BITS(FRAC_BITS)) u_chr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .item_i  (in_item),
    .valid_o (chr_valid),
    .item_o  (chr_item)
  );

  grhs_inv #(.FRAC_BITS(FRAC_BITS)) u_inv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chr_valid),
    .item_i  (chr_item),
    .valid_o (inv_valid),
    .item_o  (inv_item)
  );

  grhs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (inv_valid),
    .item_i  (inv_item),
    .valid_o (div_valid),
    .item_o  (div_item)
  );

  always_comb begin
    out_v_d = out_v_q;
    sk_v_d  = sk_v_q;
    out_ld  = 1'b0;
    sk_ld   = 1'b0;
    if (out_v_q && !m_axis_tready) begin
      if (push) begin
        sk_v_d = 1'b1;
        sk_ld  = 1'b1;
      end
    end else begin
      out_ld = 1'b1;
      if (sk_v_q) begin
        out_v_d = 1'b1;
        sk_v_d  = 1'b0;
      end else begin
        out_v_d = push;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      sk_v_q  <= sk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) out_q <= sk_v_q ? sk_q : div_item;
    if (sk_ld) sk_q <= div_item;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.accel_y, out_q.accel_x, out_q.deriv_y, out_q.deriv_x};
  assign m_axis_tuser  = out_q.singular;

endmodule

`default_nettype wire

// ===== hw/rtl/grhs_chk.sv =====
`default_nettype none

module grhs_chk (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [351:0] s_axis_tdata,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [127:0] m_axis_tdata,
  input wire logic         m_axis_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // a singular metric gives zero accelerations
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[127:64] == 64'd0)
    else $error("singular word with nonzero acceleration");

  // input back-pressure only while a result is waiting at the output
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // ready drops only after a stalled output cycle
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input ready fell without output stall");

  // an accepted word carries a known vel_y
  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !$isunknown(s_axis_tdata[351:320]))
    else $error("accepted velocity word unknown");

endmodule

bind geodesic_rhs_2d grhs_chk u_grhs_chk (.*);

`default_nettype wire
